// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: beat payloads,
// status codes, opcodes, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] value;
  } spq_req_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_prev;
    logic wr_en;
    logic wr_key;
    logic wr_prev;
    logic ptr_inc;
    logic ptr_dec;
    logic cnt_inc;
    logic cnt_dec;
    logic cap_removed;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_zero;
    logic ptr_at_cnt;
    logic greater;
  } spq_sts_t;

endpackage

// File: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Key store, read register, scan pointer, fill count and result registers.
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_req_t req_i,
  input  spq_cmd_t cmd_i,
  output spq_sts_t sts_o,
  output spq_rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_q;
  logic signed [31:0] key_q;
  logic signed [31:0] removed_q;
  logic [1:0]         status_q;
  logic [CW-1:0]      ptr_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      ptr_prev;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  assign ptr_prev = ptr_q - CW'(1);
  assign rd_addr  = cmd_i.rd_prev ? ptr_prev[AW-1:0] : ptr_q[AW-1:0];
  assign wr_addr  = cmd_i.wr_prev ? ptr_prev[AW-1:0] : ptr_q[AW-1:0];
  assign wr_data  = cmd_i.wr_key ? key_q : rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= req_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      count_q   <= '0;
      removed_q <= '0;
      status_q  <= STAT_OK;
    end else begin
      if (cmd_i.load) begin
        ptr_q     <= (req_i.opcode == OP_INSERT) ? count_q : '0;
        removed_q <= '0;
        if (req_i.opcode == OP_DELETE && sts_o.empty) begin
          status_q <= STAT_EMPTY;
        end else if (req_i.opcode == OP_INSERT && sts_o.full) begin
          status_q <= STAT_FULL;
        end else begin
          status_q <= STAT_OK;
        end
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + CW'(1);
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_prev;
      end
      if (cmd_i.cap_removed) begin
        removed_q <= rd_data_q;
      end
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign sts_o.full       = (count_q == CW'(DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.ptr_zero   = (ptr_q == '0);
  assign sts_o.ptr_at_cnt = (ptr_q == count_q);
  assign sts_o.greater    = (rd_data_q > key_q);

  assign rsp_o.removed_value = removed_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.occupancy     = 5'(count_q);

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && !cmd_i.wr_prev) |-> ptr_q < CW'(DEPTH))
    else $error("store write beyond depth");
`endif

endmodule

// File: rtl/spq_controller.sv
// ----------------------------------------------------------------------------
// spq_controller
// Sequencer for insert (scan down from the top, shift larger keys up) and
// delete-min (take the head, shift the rest down), one store access a step.
// ----------------------------------------------------------------------------
module spq_controller import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     opcode_i,
  input  spq_sts_t sts_i,
  output spq_cmd_t cmd_o,
  output logic     busy,
  output logic     done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_DEL_RD,
    ST_DEL_HEAD,
    ST_DEL_CHK,
    ST_DEL_MOV
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (opcode_i == OP_INSERT && !sts_i.full) begin
            state_d = ST_INS_CHK;
          end else if (opcode_i == OP_DELETE && !sts_i.empty) begin
            state_d = ST_DEL_RD;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      ST_INS_CHK: begin
        if (sts_i.ptr_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_key  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.greater) begin
          cmd_o.ptr_dec = 1'b1;
          state_d       = ST_INS_CHK;
        end else begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DEL_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = ST_DEL_HEAD;
      end
      ST_DEL_HEAD: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = ST_DEL_CHK;
      end
      ST_DEL_CHK: begin
        if (sts_i.ptr_at_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_DEL_MOV;
        end
      end
      ST_DEL_MOV: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_prev = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = ST_DEL_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe while sequence still running");

  a_cmp_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS_CMP |-> $past(state_q) == ST_INS_CHK)
    else $error("compare step without preceding read");
`endif

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ascending priority queue of signed 32-bit keys held in a sorted store.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; each beat returns one
// result on rsp_o, marked by done_o for exactly one cycle, which the receiver
// must take then. The store is accessed at most once a step, and every step of
// a scan is a read followed by a compare/write: an insert scans down past the
// larger keys and writes the key below them or at the head, a delete-min
// moves every remaining key down, and an insert on a full queue or a delete on
// an empty one does no scan; done_o rises in the cycle after the last step,
// and busy is already low then.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_req_t req_i,
  output logic     done_o,
  output spq_rsp_t rsp_o
);

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

// File: tb/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A directed run covers
// delete on empty, the key extremes, equal keys, filling the store and insert
// on full. Random phases then lean toward filling, draining or a mix of both.
// A predictor keeps its own sorted copy of the store, and each response beat
// is compared field by field with the oldest predicted response.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned N_RANDOM     = 1200;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  spq_req_t req   = '0;
  logic     busy;
  logic     done;
  spq_rsp_t rsp;

  spq_req_t           pending_req[$];
  spq_rsp_t           expected_rsp[$];
  logic signed [31:0] sorted_keys[SPQ_DEPTH];
  int unsigned        key_count  = 0;
  int unsigned        n_items    = 0;
  int unsigned        n_accepted = 0;
  int unsigned        n_fail     = 0;
  int unsigned        n_cycles   = 0;
  int unsigned        idle_gap   = 0;
  int unsigned        burst_left = 0;

  sorted_priority_queue u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always #2 clk = ~clk;

  function automatic void push_req(logic op, logic signed [31:0] key);
    pending_req.push_back('{opcode: op, value: key});
  endfunction

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $signed(32'($urandom_range(0, 15)) - 32'd8);
      default: return $signed(32'($urandom));
    endcase
  endfunction

  // Insert after equal keys; delete-min shifts the rest down.
  function automatic void predict_queue_op(spq_req_t r);
    spq_rsp_t    want;
    int unsigned pos;
    want = '0;
    want.status = STAT_OK;
    if (r.opcode == OP_INSERT) begin
      if (key_count >= SPQ_DEPTH) begin
        want.status = STAT_FULL;
      end else begin
        pos = key_count;
        while (pos > 0 && $signed(sorted_keys[pos-1]) > $signed(r.value)) begin
          sorted_keys[pos] = sorted_keys[pos-1];
          pos--;
        end
        sorted_keys[pos] = r.value;
        key_count++;
      end
    end else begin
      if (key_count == 0) begin
        want.status = STAT_EMPTY;
      end else begin
        want.removed_value = sorted_keys[0];
        for (int unsigned i = 1; i < key_count; i++) sorted_keys[i-1] = sorted_keys[i];
        key_count--;
      end
    end
    want.occupancy = 5'(key_count);
    expected_rsp.push_back(want);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    logic [32:0] junk;
    junk = {1'($urandom), 32'($urandom)};
    if (rst_n) begin
      if (start && !busy) begin
        predict_queue_op(req);
        n_accepted++;
      end
      if (!start || !busy) begin
        if (idle_gap > 0 || pending_req.size() == 0) begin
          if (idle_gap > 0) idle_gap--;
          start <= 1'b0;
          req   <= junk;
        end else begin
          start <= 1'b1;
          req   <= pending_req.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    spq_rsp_t want;
    if (rst_n && done) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual %p", $time, rsp);
        n_fail++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("removed_value", want.removed_value, rsp.removed_value);
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned n_gen;
    int unsigned phase_len;
    int unsigned ins_pct;
    n_gen = 0;

    push_req(OP_DELETE, 32'sd0);
    push_req(OP_INSERT, 32'sd0);
    push_req(OP_INSERT, 32'sh7fff_ffff);
    push_req(OP_INSERT, 32'sh8000_0000);
    push_req(OP_INSERT, -32'sd1);
    push_req(OP_INSERT, 32'sd1);
    push_req(OP_INSERT, 32'sd5);
    push_req(OP_INSERT, 32'sd5);
    push_req(OP_INSERT, -32'sd5);
    push_req(OP_INSERT, 32'sh7fff_ffff);
    push_req(OP_INSERT, 32'sh8000_0000);
    push_req(OP_INSERT, 32'sh5555_5555);
    push_req(OP_INSERT, 32'shaaaa_aaaa);
    push_req(OP_INSERT, 32'sd100);
    push_req(OP_INSERT, -32'sd100);
    push_req(OP_INSERT, 32'sd7);
    push_req(OP_INSERT, 32'sd3);
    push_req(OP_INSERT, 32'sd42);
    push_req(OP_DELETE, 32'shffff_ffff);
    push_req(OP_DELETE, 32'sd0);
    push_req(OP_DELETE, 32'sd0);

    while (n_gen < N_RANDOM) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      repeat (phase_len) begin
        push_req(($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_DELETE, pick_key());
        n_gen++;
      end
    end
    n_items = pending_req.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_items) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_datapath.sv
rtl/spq_controller.sv
rtl/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
